### rtl/core/nnis_pkg.sv
package nnis_pkg;

    // Field and register widths
    localparam int CMD_W       = 2;
    localparam int PIXEL_W     = 32;
    localparam int CFG_DIM_W   = 11;
    localparam int CFG_STEP_W  = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 3;

    // Percent scale of the step registers
    localparam int PCT_SCALE   = 100;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd4;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0]  SRC_WIDTH_RST  = 11'd1;
    localparam logic [CFG_DIM_W-1:0]  DST_WIDTH_RST  = 11'd1;
    localparam logic [CFG_DIM_W-1:0]  DST_HEIGHT_RST = 11'd1;
    localparam logic [CFG_STEP_W-1:0] X_STEP_RST     = 17'd100;
    localparam logic [CFG_STEP_W-1:0] Y_STEP_RST     = 17'd100;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [PIXEL_W-1:0] pixel_in;
    } nnis_in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               end_of_frame;
        logic               out_of_range;
    } nnis_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_READ,
        ST_OUT
    } nnis_state_t;

    // Stage enables from the sequencer to the index pipeline
    typedef struct packed {
        logic mul_en;
        logic div_en;
        logic sum_en;
    } nnis_ctrl_t;

endpackage

### rtl/core/nnis_index.sv
module nnis_index #(
    parameter int CW = 10,
    parameter int LW = 17
) (
    input  logic                             clk,
    input  nnis_pkg::nnis_ctrl_t             ctrl,
    input  logic [CW-1:0]                    col,
    input  logic [CW-1:0]                    row,
    input  logic [nnis_pkg::CFG_STEP_W-1:0]  x_step,
    input  logic [nnis_pkg::CFG_STEP_W-1:0]  y_step,
    input  logic [nnis_pkg::CFG_DIM_W-1:0]   src_width,
    input  logic [LW-1:0]                    loaded_count,
    output logic [CW+nnis_pkg::CFG_STEP_W+5:0] index,
    output logic                             in_range
);
    import nnis_pkg::*;

    localparam int PW          = CW + CFG_STEP_W;
    localparam int QW          = PW - 6;
    localparam int IW          = QW + CFG_DIM_W + 1;
    localparam int RECIP_SHIFT = PW + 7;
    localparam int RECIP_W     = PW + 1;
    localparam int FW          = 2 * PW + 1;
    localparam int CMP_W       = (IW > LW) ? IW : LW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PW-1:0] prod_x_reg;
    logic [PW-1:0] prod_y_reg;
    logic [QW-1:0] quo_x_reg;
    logic [QW-1:0] quo_y_reg;
    logic [IW-1:0] index_reg;
    logic          in_range_reg;

    logic [FW-1:0] frac_x;
    logic [FW-1:0] frac_y;
    logic [IW-1:0] index_next;
    logic          in_range_next;

    // Divide by the percent scale through an exact reciprocal multiply
    assign frac_x = FW'(prod_x_reg) * FW'(RECIP);
    assign frac_y = FW'(prod_y_reg) * FW'(RECIP);

    assign index_next    = IW'(quo_x_reg) + IW'(src_width) * IW'(quo_y_reg);
    assign in_range_next = CMP_W'(index_next) < CMP_W'(loaded_count);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_x_reg <= PW'(col) * PW'(x_step);
            prod_y_reg <= PW'(row) * PW'(y_step);
        end
        if (ctrl.div_en)
        begin
            quo_x_reg <= frac_x[RECIP_SHIFT +: QW];
            quo_y_reg <= frac_y[RECIP_SHIFT +: QW];
        end
        if (ctrl.sum_en)
        begin
            index_reg    <= index_next;
            in_range_reg <= in_range_next;
        end
    end

    assign index    = index_reg;
    assign in_range = in_range_reg;

endmodule

### rtl/core/nnis_store.sv
module nnis_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [nnis_pkg::PIXEL_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [nnis_pkg::PIXEL_W-1:0] rd_data
);
    import nnis_pkg::*;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/nearest_neighbor_image_scaler_unit.sv
// Nearest-neighbor scaler over a source frame held in one synchronous memory.
// A load or restart transfer leaves busy low. An emit transfer holds busy high
// until the result shows: products of the scan counters and steps are registered
// at acceptance, then come the divide by 100 (reciprocal multiply) in ST_DIV, the
// index add with the loaded-count compare in ST_SUM, and the memory read in
// ST_READ. The result is shown on result for exactly one cycle with result_valid
// high, in ST_OUT; the receiver cannot stall it, and a new command may be given
// in that same cycle. Source memory contents are undefined after reset and are
// not cleared; only entries loaded since reset or restart reach pixel_out.
module nearest_neighbor_image_scaler_unit #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_DIM    = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  nnis_pkg::nnis_in_t              request,
    output logic                            result_valid,
    output nnis_pkg::nnis_out_t             result,
    input  logic                            cfg_we,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nnis_pkg::*;

    localparam int CW    = $clog2(MAX_DIM);
    localparam int LW    = $clog2(MAX_PIXELS + 1);
    localparam int AW    = $clog2(MAX_PIXELS);
    localparam int IW    = CW + CFG_STEP_W + 6;
    localparam int CMP_W = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;

    nnis_state_t state_reg, state_next;
    nnis_ctrl_t  ctrl;

    logic [CFG_DIM_W-1:0]  src_width_reg;
    logic [CFG_DIM_W-1:0]  dst_width_reg;
    logic [CFG_DIM_W-1:0]  dst_height_reg;
    logic [CFG_STEP_W-1:0] x_step_reg;
    logic [CFG_STEP_W-1:0] y_step_reg;

    logic [LW-1:0] loaded_count_reg, loaded_count_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic          eof_reg, eof_next;

    logic             ready;
    logic             accept;
    logic             load_en;
    logic             emit_en;
    logic             rd_en;
    logic [CMP_W-1:0] width_clamp;
    logic [CMP_W-1:0] height_clamp;
    logic [CMP_W-1:0] dst_w_ext;
    logic [CMP_W-1:0] dst_h_ext;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;
    logic [IW-1:0]    index;
    logic             in_range;
    logic [PIXEL_W-1:0] rd_data;

    assign accept  = start && ready;
    assign load_en = accept && (request.command == CMD_LOAD)
                     && (loaded_count_reg != LW'(MAX_PIXELS));
    assign emit_en = accept && (request.command == CMD_EMIT);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        ready        = 1'b0;
        rd_en        = 1'b0;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready       = 1'b1;
                ctrl.mul_en = start && (request.command == CMD_EMIT);
                if (ctrl.mul_en)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctrl.div_en = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                ctrl.sum_en = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Result shows now; take the next command in the same cycle
                result_valid = 1'b1;
                ready        = 1'b1;
                ctrl.mul_en  = start && (request.command == CMD_EMIT);
                state_next   = ctrl.mul_en ? ST_DIV : ST_IDLE;
            end
        endcase
    end

    assign busy = !ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_WIDTH_RST;
            dst_width_reg  <= DST_WIDTH_RST;
            dst_height_reg <= DST_HEIGHT_RST;
            x_step_reg     <= X_STEP_RST;
            y_step_reg     <= Y_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_X_STEP:     x_step_reg     <= cfg_data[CFG_STEP_W-1:0];
                REG_Y_STEP:     y_step_reg     <= cfg_data[CFG_STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp destination size into one to MAX_DIM
    assign dst_w_ext = CMP_W'(dst_width_reg);
    assign dst_h_ext = CMP_W'(dst_height_reg);

    always_comb
    begin
        priority if (dst_w_ext == '0)
            width_clamp = CMP_W'(1);
        else if (dst_w_ext > CMP_W'(MAX_DIM))
            width_clamp = CMP_W'(MAX_DIM);
        else
            width_clamp = dst_w_ext;

        priority if (dst_h_ext == '0)
            height_clamp = CMP_W'(1);
        else if (dst_h_ext > CMP_W'(MAX_DIM))
            height_clamp = CMP_W'(MAX_DIM);
        else
            height_clamp = dst_h_ext;
    end

    assign col_inc = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc = CMP_W'(row_reg) + CMP_W'(1);

    // Scan counters and loaded count
    always_comb
    begin
        col_next          = col_reg;
        row_next          = row_reg;
        eof_next          = eof_reg;
        loaded_count_next = loaded_count_reg;
        if (load_en)
        begin
            loaded_count_next = loaded_count_reg + LW'(1);
        end
        if (accept && (request.command == CMD_RESTART))
        begin
            col_next          = '0;
            row_next          = '0;
            loaded_count_next = '0;
        end
        if (emit_en)
        begin
            eof_next = 1'b0;
            if (col_inc >= width_clamp)
            begin
                col_next = '0;
                if (row_inc >= height_clamp)
                begin
                    row_next = '0;
                    eof_next = 1'b1;
                end
                else
                begin
                    row_next = row_inc[CW-1:0];
                end
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            eof_reg          <= 1'b0;
            loaded_count_reg <= '0;
        end
        else
        begin
            col_reg          <= col_next;
            row_reg          <= row_next;
            eof_reg          <= eof_next;
            loaded_count_reg <= loaded_count_next;
        end
    end

    nnis_index #(
        .CW (CW),
        .LW (LW)
    ) u_index (
        .clk          (clk),
        .ctrl         (ctrl),
        .col          (col_reg),
        .row          (row_reg),
        .x_step       (x_step_reg),
        .y_step       (y_step_reg),
        .src_width    (src_width_reg),
        .loaded_count (loaded_count_reg),
        .index        (index),
        .in_range     (in_range)
    );

    nnis_store #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (loaded_count_reg[AW-1:0]),
        .wr_data (request.pixel_in),
        .rd_en   (rd_en),
        .rd_addr (index[AW-1:0]),
        .rd_data (rd_data)
    );

    assign result.pixel_out    = in_range ? rd_data : '0;
    assign result.end_of_frame = eof_reg;
    assign result.out_of_range = !in_range;

endmodule

### rtl/core/nnis_checker.sv
module nnis_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input nnis_pkg::nnis_in_t  request,
    input logic                result_valid,
    input nnis_pkg::nnis_out_t result
);
    import nnis_pkg::*;

    logic emit_xfer;
    logic other_xfer;

    assign emit_xfer  = start && !busy && (request.command == CMD_EMIT);
    assign other_xfer = start && !busy && (request.command != CMD_EMIT);

    // A result strobe lasts one cycle
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // Every result follows a matching emit transfer
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(emit_xfer, 4))
        else $error("result without matching emit transfer");

    // An emit keeps the unit busy while the index is worked out
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit_xfer |=> busy)
        else $error("emit transfer did not raise busy");

    // Load, restart and the unused code leave the unit free
    a_other_free: assert property (@(posedge clk) disable iff (!rst_n)
        other_xfer |=> !busy)
        else $error("non-emit transfer raised busy");

    // Out-of-range results carry a zero pixel
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_of_range) |-> (result.pixel_out == '0))
        else $error("out-of-range result with nonzero pixel");

endmodule

bind nearest_neighbor_image_scaler_unit nnis_checker u_nnis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nnis_pkg::*;

    localparam int MAX_PIXELS    = 65536;
    localparam int MAX_DIM       = 1024;
    localparam int STEP_MAX      = (1 << CFG_STEP_W) - 1;
    localparam int DIM_FIELD_MAX = (1 << CFG_DIM_W) - 1;
    localparam int IDLE_PCT      = 38;
    localparam int LONG_GAP_PCT  = 4;
    localparam int QUIET_FIRST   = 300;
    localparam int QUIET_LAST    = 500;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    nnis_in_t              request = '0;
    logic                  result_valid;
    nnis_out_t             result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Scaler state as the checker sees it
    logic [PIXEL_W-1:0]    src_copy [MAX_PIXELS];
    int unsigned           ld_count = 0;
    int unsigned           col_pos = 0;
    int unsigned           row_pos = 0;
    logic [CFG_DIM_W-1:0]  reg_src_w = SRC_WIDTH_RST;
    logic [CFG_DIM_W-1:0]  reg_dst_w = DST_WIDTH_RST;
    logic [CFG_DIM_W-1:0]  reg_dst_h = DST_HEIGHT_RST;
    logic [CFG_STEP_W-1:0] reg_x_step = X_STEP_RST;
    logic [CFG_STEP_W-1:0] reg_y_step = Y_STEP_RST;

    nnis_in_t              cmd_queue [$];
    nnis_out_t             due_pixels [$];
    nnis_out_t             want;
    int                    queued_items = 0;
    int                    sent_count = 0;
    int                    errors = 0;
    int                    stall_cycles = 0;
    int                    gap_left = 0;
    int                    idle_roll;

    nearest_neighbor_image_scaler_unit #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_DIM    (MAX_DIM)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned clamp_size(logic [CFG_DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic void set_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SRC_WIDTH:  reg_src_w = data[CFG_DIM_W-1:0];
            REG_DST_WIDTH:  reg_dst_w = data[CFG_DIM_W-1:0];
            REG_DST_HEIGHT: reg_dst_h = data[CFG_DIM_W-1:0];
            REG_X_STEP:     reg_x_step = data[CFG_STEP_W-1:0];
            REG_Y_STEP:     reg_y_step = data[CFG_STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the scaler by one command; an emit queues the pixel it must produce
    function automatic void apply_command(nnis_in_t item);
        logic [63:0] x_src;
        logic [63:0] y_src;
        logic [63:0] src_index;
        int unsigned w;
        int unsigned h;
        nnis_out_t   pix;
        case (item.command)
            CMD_LOAD:
            begin
                if (ld_count < MAX_PIXELS)
                begin
                    src_copy[ld_count] = item.pixel_in;
                    ld_count++;
                end
            end
            CMD_RESTART:
            begin
                col_pos = 0;
                row_pos = 0;
                ld_count = 0;
            end
            CMD_EMIT:
            begin
                x_src = (64'(col_pos) * 64'(reg_x_step)) / 64'(PCT_SCALE);
                y_src = (64'(row_pos) * 64'(reg_y_step)) / 64'(PCT_SCALE);
                src_index = x_src + 64'(reg_src_w) * y_src;
                pix = '0;
                pix.out_of_range = 1'b1;
                if (src_index < 64'(ld_count))
                begin
                    pix.pixel_out = src_copy[int'(src_index)];
                    pix.out_of_range = 1'b0;
                end
                w = clamp_size(reg_dst_w);
                h = clamp_size(reg_dst_h);
                // a counter past a lowered size wraps like one at the last position
                if (col_pos + 1 >= w)
                begin
                    col_pos = 0;
                    if (row_pos + 1 >= h)
                    begin
                        row_pos = 0;
                        pix.end_of_frame = 1'b1;
                    end
                    else
                        row_pos++;
                end
                else
                    col_pos++;
                due_pixels.push_back(pix);
            end
            default: ;
        endcase
    endfunction

    // Driver: hold a pending transfer while busy, otherwise send or idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (cfg_we)
                set_register(cfg_index, cfg_data);
            if (start && !busy)
            begin
                apply_command(request);
                sent_count++;
            end
            if (!(start && busy))
            begin
                idle_roll = $urandom_range(99);
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_queue.size() != 0 &&
                         ((sent_count >= QUIET_FIRST && sent_count < QUIET_LAST) ||
                          idle_roll >= IDLE_PCT))
                begin
                    start <= 1'b1;
                    request <= cmd_queue.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                    if (idle_roll < LONG_GAP_PCT)
                        gap_left = $urandom_range(1, 6);
                end
            end
        end
    end

    task automatic check_field(string label, logic [PIXEL_W-1:0] exp_val,
                               logic [PIXEL_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, label, exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (due_pixels.size() == 0)
            begin
                $display("%0t: result with none pending: actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = due_pixels.pop_front();
                check_field("pixel_out", want.pixel_out, result.pixel_out);
                check_field("end_of_frame", 32'(want.end_of_frame),
                            32'(result.end_of_frame));
                check_field("out_of_range", 32'(want.out_of_range),
                            32'(result.out_of_range));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic void queue_cmd(logic [CMD_W-1:0] c, logic [PIXEL_W-1:0] p);
        nnis_in_t item;
        item.command = c;
        item.pixel_in = p;
        cmd_queue.push_back(item);
        if (c != CMD_UNUSED)
            queued_items++;
    endfunction

    // Wait until every command is sent and every pixel is back, then let the block go quiet
    task automatic settle();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || start || due_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
    endtask

    task automatic set_scaling(logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] dw,
                               logic [CFG_DATA_W-1:0] dh, logic [CFG_DATA_W-1:0] xs,
                               logic [CFG_DATA_W-1:0] ys, bit spare);
        settle();
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_X_STEP, xs);
        write_reg(REG_Y_STEP, ys);
        if (spare)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        if (r == 1)
            return DIM_FIELD_MAX;
        if (r == 2)
            return MAX_DIM;
        return $urandom_range(1, 8);
    endfunction

    // Sometimes set bits above the register width; the block must drop them
    function automatic logic [CFG_DATA_W-1:0] dim_data(int v);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(v);
        if ($urandom_range(4) == 0)
            d = d | (CFG_DATA_W'($urandom_range(1, 63)) << CFG_DIM_W);
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step(int src, int dst);
        int r;
        int s;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CFG_DATA_W'(STEP_MAX);
        if (r == 2)
            return CFG_DATA_W'($urandom_range(0, STEP_MAX));
        s = PCT_SCALE * src / int'(clamp_size(CFG_DIM_W'(dst)));
        if (s > STEP_MAX)
            s = STEP_MAX;
        return CFG_DATA_W'(s);
    endfunction

    task automatic random_frame();
        int sw;
        int dw;
        int dh;
        int src_rows;
        int loads;
        int emits;
        int frame;
        sw = pick_dim();
        dw = pick_dim();
        dh = pick_dim();
        src_rows = $urandom_range(1, 6);
        set_scaling(dim_data(sw), dim_data(dw), dim_data(dh), pick_step(sw, dw),
                    pick_step(src_rows, dh), $urandom_range(3) == 0);
        if (sw >= 1 && sw <= 8)
            loads = sw * src_rows;
        else
            loads = $urandom_range(1, 40);
        // short source: the far pixels come back out of range
        if ($urandom_range(9) == 0)
            loads = $urandom_range(0, loads);
        frame = clamp_size(CFG_DIM_W'(dw)) * clamp_size(CFG_DIM_W'(dh));
        emits = $urandom_range(1, (2 * frame < 40) ? 2 * frame : 40);
        if ($urandom_range(9) != 0)
            queue_cmd(CMD_RESTART, $urandom);
        repeat (loads)
            queue_cmd(CMD_LOAD, $urandom);
        repeat (emits)
        begin
            if ($urandom_range(9) == 0)
                queue_cmd(CMD_W'($urandom_range(0, 3)), $urandom);
            queue_cmd(CMD_EMIT, $urandom);
        end
    endtask

    initial
    begin
        int goal;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: one-pixel frames, every emit ends a frame
        queue_cmd(CMD_EMIT, '0);
        queue_cmd(CMD_LOAD, '1);
        queue_cmd(CMD_LOAD, '0);
        queue_cmd(CMD_EMIT, '0);
        queue_cmd(CMD_UNUSED, '1);
        queue_cmd(CMD_EMIT, '1);
        queue_cmd(CMD_RESTART, '1);
        queue_cmd(CMD_EMIT, '0);
        queue_cmd(CMD_LOAD, 32'h0F0F_0F0F);

        // 2x2 source scaled up to 4x2
        set_scaling(CFG_DATA_W'(2), CFG_DATA_W'(4), CFG_DATA_W'(2),
                    CFG_DATA_W'(PCT_SCALE / 2), CFG_DATA_W'(PCT_SCALE), 1'b1);
        queue_cmd(CMD_RESTART, '0);
        repeat (4)
            queue_cmd(CMD_LOAD, $urandom);
        repeat (8)
            queue_cmd(CMD_EMIT, $urandom);

        goal = queued_items + RANDOM_ITEMS;
        while (queued_items < goal)
            random_frame();

        // Run deep into a huge frame, then shrink it under the counters
        set_scaling(CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM),
                    CFG_DATA_W'(STEP_MAX), CFG_DATA_W'(STEP_MAX), 1'b0);
        queue_cmd(CMD_RESTART, '0);
        repeat (16)
            queue_cmd(CMD_LOAD, $urandom);
        repeat (20)
            queue_cmd(CMD_EMIT, '0);
        set_scaling(CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(3), CFG_DATA_W'(1),
                    CFG_DATA_W'(STEP_MAX), CFG_DATA_W'(STEP_MAX), 1'b0);
        repeat (6)
            queue_cmd(CMD_EMIT, '0);

        settle();
        if (errors == 0 && due_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
